>>> hdl/c2s_pkg.sv
// Shared constants, types and the arctangent table for the cartesian to
// spherical converter. No dependencies.
package c2s_pkg;

   // Coordinate and product widths
   localparam int COORD_W    = 32;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int RAD_W      = 32;
   localparam int ANG_OUT_W  = 31;
   localparam int SHIFT_W    = 5;
   localparam int S_MAX      = 16;
   localparam int SQRT_STEPS = SQ_W / 2;

   // CORDIC datapath
   localparam int VEC_W      = 64;
   localparam int ACC_W      = 34;
   localparam int GRP_W      = 8;
   localparam int GRP_N      = VEC_W / GRP_W;
   localparam int GRP_IDX_W  = $clog2(GRP_N);
   localparam int POS_W      = $clog2(GRP_W);
   localparam int K_W        = $clog2(VEC_W);
   localparam int NORM_TOP   = VEC_W - 6;
   localparam int NORM_LAT   = 4;
   localparam int ATAN_LEN   = 40;
   localparam int ATAN_W     = 30;
   localparam int CORDIC_STAGES_DEF = 30;

   localparam logic [COORD_W-1:0] X_SHIFT_RESET = 32'h0001_0000;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // pi/2 in accumulator units of pi/2^31
   localparam acc_type HALF_PI = 34'sd1073741824;

   // atan(2^-i) scaled by 2^31/pi, rounded
   localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
      30'd1, 30'd0, 30'd0, 30'd0, 30'd0,
      30'd0, 30'd0, 30'd0, 30'd0, 30'd0
   };

endpackage

>>> hdl/c2s_delay.sv
// Fixed-depth delay line used to align side data and valid bits with the
// long arithmetic units. No dependencies.
module c2s_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift line, cleared on reset so valid bits start low
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

>>> hdl/c2s_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on c2s_pkg.
module c2s_sqrt (
   input  logic                        clock,
   input  logic [c2s_pkg::SQ_W-1:0]    radicand,
   output logic [c2s_pkg::RAD_W-1:0]   root
);
   import c2s_pkg::*;

   logic [SQ_W-1:0] rem_ff [SQRT_STEPS];
   logic [SQ_W-1:0] res_ff [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
      logic [SQ_W-1:0] rem_prev;
      logic [SQ_W-1:0] res_prev;
      logic [SQ_W-1:0] trial;
      logic            take;

      if (j == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      // trial subtract of res + bit
      assign trial = res_prev + BIT;
      assign take  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         res_ff[j] <= take ? ((res_prev >> 1) + BIT) : (res_prev >> 1);
      end

      // remainder is dead after the last step
      if (j < SQRT_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[j] <= take ? (rem_prev - trial) : rem_prev;
         end
      end else begin : g_rem_last
         always_ff @(posedge clock) begin
            rem_ff[j] <= '0;
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][RAD_W-1:0];

endmodule

>>> hdl/c2s_cordic.sv
// Vectoring CORDIC: normalizes (a, b) and accumulates atan2(b, a) on top of
// a start angle. Depends on c2s_pkg.
module c2s_cordic #(
   parameter int STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  c2s_pkg::vec_type  a_in,
   input  c2s_pkg::vec_type  b_in,
   input  c2s_pkg::acc_type  ang_in,
   output c2s_pkg::acc_type  ang_out
);
   import c2s_pkg::*;

   // normalize stage 0: larger magnitude
   logic [VEC_W-1:0] b_abs;
   logic [VEC_W-1:0] m0_in;
   logic [VEC_W-1:0] m0_ff;
   vec_type          a0_ff, b0_ff;
   acc_type          ang0_ff;

   assign b_abs = b_in[VEC_W-1] ? VEC_W'(-b_in) : VEC_W'(b_in);
   assign m0_in = (VEC_W'(a_in) > b_abs) ? VEC_W'(a_in) : b_abs;

   always_ff @(posedge clock) begin
      m0_ff   <= m0_in;
      a0_ff   <= a_in;
      b0_ff   <= b_in;
      ang0_ff <= ang_in;
   end

   // normalize stage 1: per-byte nonzero flag and top bit
   logic [GRP_N-1:0] nz1_in, nz1_ff;
   logic [POS_W-1:0] pos1_in [GRP_N];
   logic [POS_W-1:0] pos1_ff [GRP_N];
   vec_type          a1_ff, b1_ff;
   acc_type          ang1_ff;

   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         nz1_in[g]  = |m0_ff[g*GRP_W +: GRP_W];
         pos1_in[g] = '0;
         for (int t = 0; t < GRP_W; t++) begin
            if (m0_ff[g*GRP_W + t]) pos1_in[g] = POS_W'(t);
         end
      end
   end

   always_ff @(posedge clock) begin
      nz1_ff  <= nz1_in;
      pos1_ff <= pos1_in;
      a1_ff   <= a0_ff;
      b1_ff   <= b0_ff;
      ang1_ff <= ang0_ff;
   end

   // normalize stage 2: shift count to bring the top bit to NORM_TOP
   logic [K_W-1:0] msb_pos;
   logic           found;
   logic [K_W-1:0] k2_in, k2_ff;
   vec_type        a2_ff, b2_ff;
   acc_type        ang2_ff;

   always_comb begin
      msb_pos = '0;
      found   = 1'b0;
      for (int g = 0; g < GRP_N; g++) begin
         if (nz1_ff[g]) begin
            found   = 1'b1;
            msb_pos = {GRP_IDX_W'(g), pos1_ff[g]};
         end
      end
      if (!found) begin
         k2_in = K_W'(NORM_TOP);
      end else if (msb_pos < K_W'(NORM_TOP)) begin
         k2_in = K_W'(NORM_TOP) - msb_pos;
      end else begin
         k2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      k2_ff   <= k2_in;
      a2_ff   <= a1_ff;
      b2_ff   <= b1_ff;
      ang2_ff <= ang1_ff;
   end

   // normalize stage 3: apply the shift
   vec_type a3_ff, b3_ff;
   acc_type ang3_ff;

   always_ff @(posedge clock) begin
      a3_ff   <= a2_ff <<< k2_ff;
      b3_ff   <= b2_ff <<< k2_ff;
      ang3_ff <= ang2_ff;
   end

   // micro-rotations, one per stage
   vec_type xr_ff [STAGES];
   vec_type yr_ff [STAGES];
   acc_type zr_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam acc_type STEP = $signed({{(ACC_W-ATAN_W){1'b0}}, ATAN_TAB[i]});
      vec_type xp, yp;
      acc_type zp;
      vec_type xn, yn;
      acc_type zn;

      if (i == 0) begin : g_first
         assign xp = a3_ff;
         assign yp = b3_ff;
         assign zp = ang3_ff;
      end else begin : g_next
         assign xp = xr_ff[i-1];
         assign yp = yr_ff[i-1];
         assign zp = zr_ff[i-1];
      end

      always_comb begin
         if (!yp[VEC_W-1]) begin
            xn = xp + (yp >>> i);
            yn = yp - (xp >>> i);
            zn = zp + STEP;
         end else begin
            xn = xp - (yp >>> i);
            yn = yp + (xp >>> i);
            zn = zp - STEP;
         end
      end

      always_ff @(posedge clock) begin
         zr_ff[i] <= zn;
      end

      // vector state is dead after the last rotation
      if (i < STAGES - 1) begin : g_vec
         always_ff @(posedge clock) begin
            xr_ff[i] <= xn;
            yr_ff[i] <= yn;
         end
      end else begin : g_vec_last
         always_ff @(posedge clock) begin
            xr_ff[i] <= '0;
            yr_ff[i] <= '0;
         end
      end
   end

   assign ang_out = zr_ff[STAGES-1];

endmodule

>>> hdl/cartesian_to_spherical_top.sv
// Cartesian to spherical converter, top level: front pipeline, two square
// roots, two CORDICs and output register. Depends on c2s_pkg, c2s_delay,
// c2s_sqrt and c2s_cordic.
//
// One beat in per clock, one result beat out per input, in order. busy is
// always low, so start is taken in every cycle. A beat passes 6 front
// stages (input, shift, squares, sums, scale count, scale), 32 square-root
// stages, 1 operand stage, 4 normalize stages plus CORDIC_STAGES rotation
// stages, and the output register, before rsp_strobe goes high. The result is
// shown for one cycle only and cannot be held off, so the receiver must take
// every beat. Write csr_wr_data only while no beat is in flight.
module cartesian_to_spherical_top #(
   parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_kind,
   input  logic signed [c2s_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [c2s_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [c2s_pkg::COORD_W-1:0]    req_coord_z,
   output logic                                  rsp_strobe,
   output logic [c2s_pkg::RAD_W-1:0]             rsp_radius,
   output logic [c2s_pkg::ANG_OUT_W-1:0]         rsp_polar_angle,
   output logic signed [c2s_pkg::ANG_OUT_W-1:0]  rsp_azimuth_angle,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_wr_en,
   input  logic [c2s_pkg::COORD_W-1:0]           csr_wr_data
);
   import c2s_pkg::*;

   localparam int CORDIC_LAT = NORM_LAT + CORDIC_STAGES;
   localparam int XYZ_W      = 1 + VEC_W + 2 * COORD_W;
   localparam int SIDE_W     = 4 + RAD_W;

   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
      mag = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
   endfunction

   assign busy = 1'b0;

   // configuration register
   logic [COORD_W-1:0] x_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_shift_ff <= X_SHIFT_RESET;
      end else if (csr_wr_en) begin
         x_shift_ff <= csr_wr_data;
      end
   end

   // stage 1: input register
   logic                      v1_ff, kind1_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, z1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start & ~busy;
      kind1_ff <= req_kind;
      x1_ff    <= req_coord_x;
      y1_ff    <= req_coord_y;
      z1_ff    <= req_coord_z;
   end

   // stage 2: saturating x shift for positions
   logic                      v2_ff;
   logic signed [COORD_W:0]   xsum;
   logic signed [COORD_W-1:0] x2_in;
   logic signed [COORD_W-1:0] x2_ff, y2_ff, z2_ff;

   always_comb begin
      xsum = {x1_ff[COORD_W-1], x1_ff} + {x_shift_ff[COORD_W-1], x_shift_ff};
      if (!kind1_ff) begin
         x2_in = x1_ff;
      end else if (xsum[COORD_W] != xsum[COORD_W-1]) begin
         x2_in = xsum[COORD_W] ? C_MIN : C_MAX;
      end else begin
         x2_in = xsum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      x2_ff <= x2_in;
      y2_ff <= y1_ff;
      z2_ff <= z1_ff;
   end

   // stage 3: squares
   logic                      v3_ff;
   logic [SQ_W-1:0]           sqx3_ff, sqy3_ff, sqz3_ff;
   logic signed [COORD_W-1:0] x3_ff, y3_ff, z3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      sqx3_ff <= SQ_W'(mag(x2_ff)) * SQ_W'(mag(x2_ff));
      sqy3_ff <= SQ_W'(mag(y2_ff)) * SQ_W'(mag(y2_ff));
      sqz3_ff <= SQ_W'(mag(z2_ff)) * SQ_W'(mag(z2_ff));
      x3_ff   <= x2_ff;
      y3_ff   <= y2_ff;
      z3_ff   <= z2_ff;
   end

   // stage 4: sums
   logic                      v4_ff;
   logic [SQ_W-1:0]           sxy4_ff, sum4_ff;
   logic signed [COORD_W-1:0] x4_ff, y4_ff, z4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      sxy4_ff <= sqx3_ff + sqy3_ff;
      sum4_ff <= sqx3_ff + sqy3_ff + sqz3_ff;
      x4_ff   <= x3_ff;
      y4_ff   <= y3_ff;
      z4_ff   <= z3_ff;
   end

   // stage 5: scale count for rho and zero test
   // (the z bound of the count never binds at this coordinate width)
   logic                      v5_ff, zero5_ff;
   logic [SHIFT_W-1:0]        s5_in, s5_ff;
   logic [SQ_W-1:0]           sxy5_ff, sum5_ff;
   logic signed [COORD_W-1:0] x5_ff, y5_ff, z5_ff;

   always_comb begin
      s5_in = '0;
      for (int j = 0; j < S_MAX; j++) begin
         if ((sxy4_ff >> (SQ_W - 2 - 2 * j)) == '0) s5_in = s5_in + SHIFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      s5_ff    <= s5_in;
      zero5_ff <= (sum4_ff == '0);
      sxy5_ff  <= sxy4_ff;
      sum5_ff  <= sum4_ff;
      x5_ff    <= x4_ff;
      y5_ff    <= y4_ff;
      z5_ff    <= z4_ff;
   end

   // stage 6: scale rho radicand by 4^s and z by 2^s
   logic                      v6_ff, zero6_ff;
   logic [SQ_W-1:0]           sxysh6_ff, sum6_ff;
   vec_type                   zz6_ff;
   logic signed [COORD_W-1:0] x6_ff, y6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      sxysh6_ff <= sxy5_ff << {s5_ff, 1'b0};
      zz6_ff    <= VEC_W'(z5_ff) <<< s5_ff;
      sum6_ff   <= sum5_ff;
      zero6_ff  <= zero5_ff;
      x6_ff     <= x5_ff;
      y6_ff     <= y5_ff;
   end

   // square roots: radius and rho
   logic [RAD_W-1:0] radius_sq, rho_sq;

   c2s_sqrt u_sqrt_rad (
      .clock    (clock),
      .radicand (sum6_ff),
      .root     (radius_sq)
   );

   c2s_sqrt u_sqrt_rho (
      .clock    (clock),
      .radicand (sxysh6_ff),
      .root     (rho_sq)
   );

   // side data across the square roots
   logic [XYZ_W-1:0]          xyz_d;
   logic                      v_sq;
   logic                      zero_d;
   vec_type                   zz_d;
   logic signed [COORD_W-1:0] x_d, y_d;

   c2s_delay #(.WIDTH(XYZ_W), .DEPTH(SQRT_STEPS)) u_dly_xyz (
      .clock (clock),
      .reset (reset),
      .din   ({zero6_ff, zz6_ff, x6_ff, y6_ff}),
      .dout  (xyz_d)
   );

   c2s_delay #(.WIDTH(1), .DEPTH(SQRT_STEPS)) u_dly_v_sq (
      .clock (clock),
      .reset (reset),
      .din   (v6_ff),
      .dout  (v_sq)
   );

   assign {zero_d, zz_d, x_d, y_d} = xyz_d;

   // stage 7: CORDIC operands
   logic    v7_ff;
   vec_type pa7_in, pb7_in, pa7_ff, pb7_ff;
   acc_type pi7_in, pi7_ff;
   vec_type aa7_in, ab7_in, aa7_ff, ab7_ff;
   vec_type rho_ext, xs_ext, ys_ext;
   logic [SIDE_W-1:0] side7_ff;

   always_comb begin
      rho_ext = $signed({{(VEC_W-RAD_W){1'b0}}, rho_sq});
      xs_ext  = VEC_W'(x_d);
      ys_ext  = VEC_W'(y_d);
      // polar: atan2(rho, z), folded into the right half plane
      if (!zz_d[VEC_W-1]) begin
         pa7_in = zz_d;
         pb7_in = rho_ext;
         pi7_in = '0;
      end else begin
         pa7_in = rho_ext;
         pb7_in = -zz_d;
         pi7_in = HALF_PI;
      end
      // azimuth: atan(y/x) with x made positive
      if (x_d > 0) begin
         aa7_in = xs_ext;
         ab7_in = ys_ext;
      end else begin
         aa7_in = -xs_ext;
         ab7_in = -ys_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v_sq;
      pa7_ff   <= pa7_in;
      pb7_ff   <= pb7_in;
      pi7_ff   <= pi7_in;
      aa7_ff   <= aa7_in;
      ab7_ff   <= ab7_in;
      side7_ff <= {zero_d, (x_d == '0), (y_d > 0), (y_d < 0), radius_sq};
   end

   // CORDICs
   acc_type pol_ang, azi_ang;

   c2s_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pol (
      .clock   (clock),
      .a_in    (pa7_ff),
      .b_in    (pb7_ff),
      .ang_in  (pi7_ff),
      .ang_out (pol_ang)
   );

   c2s_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_azi (
      .clock   (clock),
      .a_in    (aa7_ff),
      .b_in    (ab7_ff),
      .ang_in  ('0),
      .ang_out (azi_ang)
   );

   logic [SIDE_W-1:0] side_d;
   logic              v_cd;
   logic              zero_c, xzero_c, ypos_c, yneg_c;
   logic [RAD_W-1:0]  radius_c;

   c2s_delay #(.WIDTH(SIDE_W), .DEPTH(CORDIC_LAT)) u_dly_side (
      .clock (clock),
      .reset (reset),
      .din   (side7_ff),
      .dout  (side_d)
   );

   c2s_delay #(.WIDTH(1), .DEPTH(CORDIC_LAT)) u_dly_v_cd (
      .clock (clock),
      .reset (reset),
      .din   (v7_ff),
      .dout  (v_cd)
   );

   assign {zero_c, xzero_c, ypos_c, yneg_c, radius_c} = side_d;

   // stage 8: clamp, round and output register
   acc_type pol_cl, azi_cl, pol_rnd, azi_rnd;
   logic [ANG_OUT_W-1:0]        pol_in;
   logic signed [ANG_OUT_W-1:0] azi_in;

   always_comb begin
      pol_cl = pol_ang;
      if (pol_ang < 0)            pol_cl = '0;
      if (pol_ang > 2 * HALF_PI)  pol_cl = 2 * HALF_PI;
      pol_rnd = (pol_cl + acc_type'(1)) >>> 1;

      azi_cl = azi_ang;
      if (azi_ang > HALF_PI)      azi_cl = HALF_PI;
      if (azi_ang < -HALF_PI)     azi_cl = -HALF_PI;
      azi_rnd = (azi_cl + acc_type'(1)) >>> 1;

      pol_in = pol_rnd[ANG_OUT_W-1:0];
      priority if (zero_c) begin
         pol_in = '0;
         azi_in = '0;
      end else if (xzero_c && ypos_c) begin
         azi_in = ANG_OUT_W'(HALF_PI >>> 1);
      end else if (xzero_c && yneg_c) begin
         azi_in = ANG_OUT_W'(-(HALF_PI >>> 1));
      end else if (xzero_c) begin
         azi_in = '0;
      end else begin
         azi_in = azi_rnd[ANG_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= v_cd;
      rsp_radius        <= zero_c ? '0 : radius_c;
      rsp_polar_angle   <= pol_in;
      rsp_azimuth_angle <= azi_in;
      rsp_degenerate    <= zero_c;
   end

   // checks
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |->
         rsp_radius == '0 && rsp_polar_angle == '0 && rsp_azimuth_angle == '0)
      else $error("degenerate beat with nonzero fields");

   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_polar_angle <= ANG_OUT_W'(HALF_PI))
      else $error("polar angle out of range");

   a_azimuth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_azimuth_angle <= ANG_OUT_W'(HALF_PI >>> 1)) &&
                     (rsp_azimuth_angle >= ANG_OUT_W'(-(HALF_PI >>> 1))))
      else $error("azimuth out of range");

   a_nonzero_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_degenerate |-> rsp_radius != '0)
      else $error("nonzero vector with zero radius");

endmodule
